[sv/osnq_pkg.sv]
// Shared types and constants for the ordered set with neighbor query.
package osnq_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned KeyWidth = 32;
  localparam int unsigned CountOutWidth = 7;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_ERASE    = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_LOWER    = 3'd3,
    OP_HIGHER   = 3'd4,
    OP_SIZE     = 3'd5
  } osnq_op_e;

  typedef struct packed {
    logic [2:0]                 func;
    logic signed [KeyWidth-1:0] key;
  } osnq_req_t;

  typedef struct packed {
    logic                       found;
    logic signed [KeyWidth-1:0] neighbor_key;
    logic [CountOutWidth-1:0]   count;
    logic                       full_drop;
  } osnq_rsp_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic signed [KeyWidth-1:0] key;
    logic                       ins;
    logic                       del;
  } osnq_bcast_t;

  // Compare flags of one cell.
  typedef struct packed {
    logic lt;
    logic gt;
    logic eq;
  } osnq_flags_t;

endpackage

[sv/osnq_cell.sv]
// One storage cell of the sorted key row: compare, shift and neighbor select.
module osnq_cell
  import osnq_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       occ_i,
  input  osnq_bcast_t                bcast_i,
  input  logic                       prev_lt_i,
  input  logic                       prev_gt_i,
  input  logic                       next_lt_i,
  input  logic signed [KeyWidth-1:0] prev_key_i,
  input  logic signed [KeyWidth-1:0] next_key_i,
  output logic signed [KeyWidth-1:0] key_o,
  output osnq_flags_t                flags_o,
  output logic signed [KeyWidth-1:0] lo_key_o,
  output logic signed [KeyWidth-1:0] hi_key_o
);

  logic signed [KeyWidth-1:0] key_q, key_d;
  logic                       at_pos;

  assign flags_o.lt = occ_i && (key_q < bcast_i.key);
  assign flags_o.gt = occ_i && (key_q > bcast_i.key);
  assign flags_o.eq = occ_i && (key_q == bcast_i.key);

  // First cell at or above the query key.
  assign at_pos = prev_lt_i && !flags_o.lt;

  always_comb begin
    key_d = key_q;
    if (bcast_i.ins && !flags_o.lt) begin
      key_d = at_pos ? bcast_i.key : prev_key_i;
    end else if (bcast_i.del && !flags_o.lt) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // Last cell below the query and first cell above it.
  assign lo_key_o = (flags_o.lt && !next_lt_i) ? key_q : '0;
  assign hi_key_o = (flags_o.gt && !prev_gt_i) ? key_q : '0;
  assign key_o    = key_q;

endmodule

[sv/ordered_set_with_neighbor_query.sv]
// Top level of the ordered set of signed keys with neighbor queries.
//
// Input channel in_*: one request per transaction, a function code and a
// signed key. Output channel out_*: exactly one result per request (found,
// neighbor key, count after the request, full-drop flag), in request order.
// A transaction moves at a rising edge with valid high and stall low.
// Keys sit sorted in a row of CAPACITY cells. Every cell compares its key
// with the broadcast key at once; an insert shifts the cells at and above
// the insert point up one place, an erase shifts them down one place, and
// the neighbor is picked from the one cell at the edge of the compare.
// Latency: the result is valid in the cycle after the request is taken.
// Throughput: one request per cycle, set by the single compare-and-shift
// pass over the cell row. The output register holds a result while the
// receiver stalls; a new request is taken in that cycle only if the held
// result leaves, so in_stall_o follows out_stall_i while a result waits.
// Reset empties the set (count zero) and clears the output valid flag;
// the result register and the cell contents stay undefined until written.
module ordered_set_with_neighbor_query
  import osnq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  osnq_req_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output osnq_rsp_t out_data_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]              count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  osnq_rsp_t                  rsp_q, rsp_d;
  osnq_bcast_t                bcast;
  logic                       accept, present, full;
  logic [CAPACITY-1:0]        occ, lt_vec, gt_vec, eq_vec;
  logic signed [KeyWidth-1:0] cell_key [CAPACITY];
  logic signed [KeyWidth-1:0] lo_key [CAPACITY];
  logic signed [KeyWidth-1:0] hi_key [CAPACITY];
  logic signed [KeyWidth-1:0] lo_sel, hi_sel;
  logic [CW+CountOutWidth-1:0] count_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign present = |eq_vec;
  assign full    = (count_q == CW'(CAPACITY));

  assign bcast.key = in_data_i.key;
  assign bcast.ins = accept && (in_data_i.func == OP_INSERT) && !present && !full;
  assign bcast.del = accept && (in_data_i.func == OP_ERASE) && present;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    osnq_flags_t flags;

    assign occ[g]    = (count_q > CW'(g));
    assign lt_vec[g] = flags.lt;
    assign gt_vec[g] = flags.gt;
    assign eq_vec[g] = flags.eq;

    osnq_cell u_cell (
      .clk_i      (clk_i),
      .occ_i      (occ[g]),
      .bcast_i    (bcast),
      .prev_lt_i  ((g == 0) ? 1'b1 : lt_vec[(g == 0) ? 0 : g-1]),
      .prev_gt_i  ((g == 0) ? 1'b0 : gt_vec[(g == 0) ? 0 : g-1]),
      .next_lt_i  ((g == CAPACITY-1) ? 1'b0 : lt_vec[(g == CAPACITY-1) ? g : g+1]),
      .prev_key_i (cell_key[(g == 0) ? 0 : g-1]),
      .next_key_i (cell_key[(g == CAPACITY-1) ? g : g+1]),
      .key_o      (cell_key[g]),
      .flags_o    (flags),
      .lo_key_o   (lo_key[g]),
      .hi_key_o   (hi_key[g])
    );
  end

  // At most one cell drives each select, so an OR merges them.
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      lo_sel = lo_sel | lo_key[i];
      hi_sel = hi_sel | hi_key[i];
    end
  end

  always_comb begin
    count_d = count_q;
    if (bcast.ins) begin
      count_d = count_q + 1'b1;
    end else if (bcast.del) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext = {{CountOutWidth{1'b0}}, count_d};

  always_comb begin
    rsp_d              = '0;
    rsp_d.count        = count_ext[CountOutWidth-1:0];
    case (in_data_i.func)
      OP_INSERT:   rsp_d.full_drop = !present && full;
      OP_ERASE:    rsp_d.found = present;
      OP_CONTAINS: rsp_d.found = present;
      OP_LOWER: begin
        rsp_d.found        = |lt_vec;
        rsp_d.neighbor_key = lo_sel;
      end
      OP_HIGHER: begin
        rsp_d.found        = |gt_vec;
        rsp_d.neighbor_key = hi_sel;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

endmodule

[sv/osnq_chk.sv]
// Port-level assertions for the ordered set, bound to the top level.
module osnq_chk
  import osnq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input osnq_req_t in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input osnq_rsp_t out_data_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_nbr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.neighbor_key == '0)
    else $error("neighbor key set without found");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.full_drop
      |-> out_data_o.count == 7'(CAPACITY) && !out_data_o.found)
    else $error("full drop with store not full");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 127) || (32'(out_data_o.count) <= CAPACITY))
    else $error("count above capacity");

endmodule

bind ordered_set_with_neighbor_query osnq_chk #(.CAPACITY(CAPACITY)) u_osnq_chk (.*);
